FILE: src/cbg_pkg.sv
// Shared types and constants for the clocked burst generator.
`timescale 1ns / 1ps

package cbg_pkg;

  // Default and allowed span of pulses per burst
  localparam int MAX_PULSES_DEF = 32;

  // Field widths
  localparam int LEN_W    = 6;
  localparam int RAND_W   = 16;
  localparam int THR_W    = 17;
  localparam int STEP_W   = 6;
  localparam int MARK_W   = 16;
  localparam int IN_W     = 48;
  localparam int OUT_W    = 16;

  // Configuration register indexes
  localparam logic REG_RETRIGGER    = 1'b0;
  localparam logic REG_MARKER_TICKS = 1'b1;

  // Reset value of the marker length register
  localparam logic [MARK_W-1:0] MARKER_TICKS_RST = 16'd48;

  // Per-tick result of the burst core
  typedef struct packed {
    logic              pulse;
    logic              duration;
    logic              start_fire;
    logic              end_fire;
    logic [STEP_W-1:0] step;
  } core_out_t;

endpackage

FILE: src/clocked_burst_generator_unit.sv
// Top level of the clocked burst generator: stream ports, config registers, result register.
`timescale 1ns / 1ps

// Clocked trigger burst generator.
// Each transfer on the s_axis side is one sample tick carrying trigger and
// clock levels, burst length, a random word and a probability threshold.
// Each tick produces exactly one result transfer on m_axis: gated pulse,
// burst duration, start and end markers and the expander step index.
// The result of a tick is registered: it is in the result register on
// the cycle after its transfer. Throughput is one tick per cycle while the
// receiver keeps up; the state update is a single pass of flag and counter logic.
// The result register frees up when the receiver takes its transfer, so a
// new tick is taken in the same cycle the previous result leaves. While the
// receiver stalls with a result held, s_axis_tready stays low.
// Configuration: wr_en with wr_index 0 writes retrigger_enable (bit 0),
// index 1 writes marker_ticks. Write only while no tick is in flight.
// Reset (rst, synchronous) returns the block to idle: no burst, markers
// off, retrigger disabled, marker length 48 ticks, output empty.
module clocked_burst_generator_unit #(
  parameter int MAX_PULSES = cbg_pkg::MAX_PULSES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // tdata: trigger_level[0], clock_level[1], burst_length[7:2],
  //        random_word[23:8], fire_threshold[40:24], zero fill above
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [cbg_pkg::IN_W-1:0]    s_axis_tdata,
  // tdata: pulse_out[0], duration_out[1], start_out[2], end_out[3],
  //        step_index[9:4], zero fill above
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [cbg_pkg::OUT_W-1:0]   m_axis_tdata,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [cbg_pkg::MARK_W-1:0]  wr_data
);

  logic                       retrigger_enable;
  logic [cbg_pkg::MARK_W-1:0] marker_ticks;
  logic                       accept;
  cbg_pkg::core_out_t         core_res;
  logic                       start_mark, end_mark;
  logic [cbg_pkg::OUT_W-1:0]  result;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      retrigger_enable <= 1'b0;
      marker_ticks     <= cbg_pkg::MARKER_TICKS_RST;
    end else if (wr_en) begin
      case (wr_index)
        cbg_pkg::REG_RETRIGGER:    retrigger_enable <= wr_data[0];
        cbg_pkg::REG_MARKER_TICKS: marker_ticks     <= wr_data;
        default: ;
      endcase
    end
  end

  // Take a tick when the result register is empty or being drained
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  cbg_core #(
    .MAX_PULSES(MAX_PULSES)
  ) u_core (
    .clk              (clk),
    .rst              (rst),
    .en               (accept),
    .retrigger_enable (retrigger_enable),
    .trigger_level    (s_axis_tdata[0]),
    .clock_level      (s_axis_tdata[1]),
    .burst_length     (s_axis_tdata[7:2]),
    .random_word      (s_axis_tdata[23:8]),
    .fire_threshold   (s_axis_tdata[40:24]),
    .res              (core_res)
  );

  cbg_marker u_start_marker (
    .clk          (clk),
    .rst          (rst),
    .en           (accept),
    .fire         (core_res.start_fire),
    .marker_ticks (marker_ticks),
    .mark         (start_mark)
  );

  cbg_marker u_end_marker (
    .clk          (clk),
    .rst          (rst),
    .en           (accept),
    .fire         (core_res.end_fire),
    .marker_ticks (marker_ticks),
    .mark         (end_mark)
  );

  // Pack the result item
  assign result = {6'b0, core_res.step, end_mark, start_mark,
                   core_res.duration, core_res.pulse};

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_axis_tdata <= result;
    end
  end

endmodule

FILE: src/cbg_marker.sv
// Fixed-length marker pulse timer (start or end marker).
`timescale 1ns / 1ps

module cbg_marker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       fire,
  input  logic [cbg_pkg::MARK_W-1:0] marker_ticks,
  output logic                       mark
);

  logic [cbg_pkg::MARK_W-1:0] timer;
  logic [cbg_pkg::MARK_W-1:0] timer_next;

  // Fire loads the longer of the current and configured length; else count down
  always_comb begin
    timer_next = timer;
    mark       = 1'b0;
    if (fire) begin
      if (marker_ticks > timer) begin
        timer_next = marker_ticks;
      end
    end else if (timer != '0) begin
      timer_next = timer - 1'b1;
      mark       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer <= '0;
    end else if (en) begin
      timer <= timer_next;
    end
  end

endmodule

FILE: src/cbg_core.sv
// Burst state: trigger and clock edges, pulse count, probability gate, expander step.
`timescale 1ns / 1ps

module cbg_core #(
  parameter int MAX_PULSES = cbg_pkg::MAX_PULSES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       retrigger_enable,
  input  logic                       trigger_level,
  input  logic                       clock_level,
  input  logic [cbg_pkg::LEN_W-1:0]  burst_length,
  input  logic [cbg_pkg::RAND_W-1:0] random_word,
  input  logic [cbg_pkg::THR_W-1:0]  fire_threshold,
  output cbg_pkg::core_out_t         res
);

  // Counters hold pulse index plus one, up to MAX_PULSES + 1
  localparam int CW = $clog2(MAX_PULSES + 2);

  logic          trigger_prev, clock_prev, burst_active, burst_active_prev;
  logic          start_pending, fire_flag, expander_active;
  logic [CW-1:0] pulse_count, expander_count;

  logic          clock_prev_next, burst_active_next, start_pending_next;
  logic          fire_flag_next, expander_active_next;
  logic [CW-1:0] pulse_count_next, expander_count_next;
  logic [cbg_pkg::LEN_W:0] len_w;
  logic [CW-1:0] len;
  logic          arm, rise, fall;

  always_comb begin
    // Clamp burst length to 1..MAX_PULSES
    len_w = {1'b0, burst_length};
    if (len_w == '0) begin
      len_w = (cbg_pkg::LEN_W+1)'(1);
    end else if (len_w > (cbg_pkg::LEN_W+1)'(MAX_PULSES)) begin
      len_w = (cbg_pkg::LEN_W+1)'(MAX_PULSES);
    end
    len = CW'(len_w);

    // Trigger edge arms a burst unless one runs with retrigger off; arming forces the clock history low
    arm = trigger_level && !trigger_prev && (!burst_active || retrigger_enable);
    clock_prev_next      = arm ? 1'b0 : clock_prev;
    start_pending_next   = arm ? 1'b1 : start_pending;
    pulse_count_next     = arm ? '0 : pulse_count;
    expander_active_next = arm ? 1'b1 : expander_active;
    expander_count_next  = arm ? '0 : expander_count;
    burst_active_next    = burst_active;
    fire_flag_next       = fire_flag;

    rise = clock_level && !clock_prev_next;
    fall = !clock_level && clock_prev_next;

    // Rising clock: advance counts and sample the gate
    if (rise) begin
      if (expander_active_next) begin
        expander_count_next = expander_count_next + 1'b1;
        if (expander_count_next > len) begin
          expander_count_next  = '0;
          expander_active_next = 1'b0;
        end
      end
      fire_flag_next = ({1'b0, random_word} < fire_threshold);
      if (start_pending_next || burst_active_next) begin
        pulse_count_next = pulse_count_next + 1'b1;
        if (pulse_count_next > len) begin
          pulse_count_next  = '0;
          burst_active_next = 1'b0;
        end else begin
          burst_active_next = 1'b1;
        end
        start_pending_next = 1'b0;
      end
    end

    // Falling clock after the last pulse ends the burst
    if (fall && (pulse_count_next >= len)) begin
      burst_active_next = 1'b0;
    end

    res.pulse      = burst_active_next && fire_flag_next && clock_level;
    res.duration   = burst_active_next;
    res.start_fire = !burst_active_prev && burst_active_next;
    res.end_fire   = burst_active_prev && !burst_active_next;
    res.step       = expander_active_next ? cbg_pkg::STEP_W'(pulse_count_next) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_prev      <= 1'b0;
      clock_prev        <= 1'b0;
      pulse_count       <= '0;
      burst_active      <= 1'b0;
      burst_active_prev <= 1'b0;
      start_pending     <= 1'b0;
      fire_flag         <= 1'b1;
      expander_active   <= 1'b0;
      expander_count    <= '0;
    end else if (en) begin
      trigger_prev      <= trigger_level;
      clock_prev        <= clock_level;
      pulse_count       <= pulse_count_next;
      burst_active      <= burst_active_next;
      burst_active_prev <= burst_active_next;
      start_pending     <= start_pending_next;
      fire_flag         <= fire_flag_next;
      expander_active   <= expander_active_next;
      expander_count    <= expander_count_next;
    end
  end

endmodule

FILE: verif/clocked_burst_generator_unit_tb.sv
// Self-checking testbench for the clocked burst generator top level.
`timescale 1ns / 1ps

module clocked_burst_generator_unit_tb;

  localparam int MAXP = cbg_pkg::MAX_PULSES_DEF;

  typedef struct {
    logic [cbg_pkg::IN_W-1:0] data;
    bit                       hold;
  } tick_item_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [cbg_pkg::IN_W-1:0]    s_axis_tdata = '0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [cbg_pkg::OUT_W-1:0]   m_axis_tdata;
  logic                        wr_en = 1'b0;
  logic                        wr_index = cbg_pkg::REG_RETRIGGER;
  logic [cbg_pkg::MARK_W-1:0]  wr_data = '0;

  // Ticks waiting to go out, and burst results owed by the block
  tick_item_t                  ticks_to_send[$];
  cbg_pkg::core_out_t          burst_results_due[$];

  int                          snd_idle_pct = 0;
  int                          rcv_idle_pct = 0;
  int                          mismatches = 0;
  int                          ticks_sent = 0;
  int                          bursts_armed = 0;
  int                          pulses_fired = 0;
  int                          settings_used = 0;

  // Burst model state and its copy of the registers
  logic                        retrig_en;
  logic [cbg_pkg::MARK_W-1:0]  mark_len;
  logic                        trig_q;
  logic                        clk_q;
  int                          pulse_cnt;
  logic                        active;
  logic                        active_q;
  logic                        start_pend;
  logic                        fire_ok;
  logic                        exp_on;
  logic [cbg_pkg::STEP_W-1:0]  exp_cnt;
  logic [cbg_pkg::MARK_W-1:0]  start_tmr;
  logic [cbg_pkg::MARK_W-1:0]  end_tmr;

  clocked_burst_generator_unit #(
    .MAX_PULSES(MAXP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Marker timer: arming loads the longer of the two lengths and stays quiet
  function automatic logic marker_tick(input logic arm,
                                       inout logic [cbg_pkg::MARK_W-1:0] tmr);
    if (arm) begin
      if (mark_len > tmr) tmr = mark_len;
      return 1'b0;
    end
    if (tmr != '0) begin
      tmr = tmr - 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Advance the burst model by one tick and return its result
  function automatic cbg_pkg::core_out_t next_burst_result(
      input logic [cbg_pkg::IN_W-1:0] d);
    cbg_pkg::core_out_t          r;
    logic                        trig;
    logic                        clk_l;
    logic                        rise;
    logic                        fall;
    logic [cbg_pkg::RAND_W-1:0]  rnd;
    logic [cbg_pkg::THR_W-1:0]   thr;
    int                          len;
    trig  = d[0];
    clk_l = d[1];
    len   = int'(d[7:2]);
    rnd   = d[23:8];
    thr   = d[40:24];
    if (len < 1) len = 1;
    if (len > MAXP) len = MAXP;
    // Trigger edge arms, unless a burst runs and retrigger is off
    if (trig && !trig_q && (!active || retrig_en)) begin
      clk_q      = 1'b0;
      start_pend = 1'b1;
      pulse_cnt  = -1;
      exp_on     = 1'b1;
      exp_cnt    = '0;
    end
    trig_q = trig;
    rise   = clk_l && !clk_q;
    fall   = !clk_l && clk_q;
    clk_q  = clk_l;
    // Rising clock: count pulses, resample the probability gate
    if (rise) begin
      if (exp_on) begin
        exp_cnt = exp_cnt + 1'b1;
        if (int'(exp_cnt) > len) begin
          exp_cnt = '0;
          exp_on  = 1'b0;
        end
      end
      fire_ok = (rnd < thr);
      if (start_pend || active) begin
        pulse_cnt = pulse_cnt + 1;
        if (pulse_cnt >= len) begin
          pulse_cnt = -1;
          active    = 1'b0;
        end else begin
          active = 1'b1;
        end
        start_pend = 1'b0;
      end
    end
    if (fall && pulse_cnt + 1 >= len) active = 1'b0;
    if (!active_q && active) bursts_armed++;
    r.start_fire = marker_tick(!active_q && active, start_tmr);
    r.end_fire   = marker_tick(active_q && !active, end_tmr);
    r.step       = exp_on ? cbg_pkg::STEP_W'(pulse_cnt + 1) : '0;
    r.pulse      = active && fire_ok && clk_l;
    r.duration   = active;
    if (r.pulse) pulses_fired++;
    active_q = active;
    return r;
  endfunction

  function automatic void queue_tick(input int trig, input int clk_l, input int len,
                                     input int rnd, input int thr, input int hold);
    tick_item_t it;
    it.data = {7'b0, cbg_pkg::THR_W'(thr), cbg_pkg::RAND_W'(rnd), cbg_pkg::LEN_W'(len),
               1'(clk_l), 1'(trig)};
    it.hold = (hold != 0);
    ticks_to_send.push_back(it);
  endfunction

  function automatic int pick_thr();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 65536;
      2:       return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 90) return $urandom_range(7, 32);
    if (r < 95) return 0;
    return $urandom_range(33, 63);
  endfunction

  // Mostly complete bursts (trigger, then a steady clock), some pure noise
  task automatic queue_random_ticks(input int n);
    int queued;
    int span;
    int len;
    int eff;
    int hp;
    int trig_hi;
    int phase;
    int retrig_at;
    int trig;
    queued = 0;
    while (queued < n) begin
      if ($urandom_range(0, 99) < 15) begin
        span = $urandom_range(4, 16);
        for (int t = 0; t < span; t++) begin
          queue_tick($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 63),
                     $urandom_range(0, 65535), $urandom_range(0, 131071),
                     int'($urandom_range(0, 299) == 0));
        end
      end else begin
        len     = pick_len();
        eff     = (len < 1) ? 1 : ((len > MAXP) ? MAXP : len);
        hp      = $urandom_range(1, 3);
        span    = 2 * hp * (eff + 2) + $urandom_range(0, 6);
        trig_hi = $urandom_range(1, 3);
        phase   = $urandom_range(0, 2 * hp - 1);
        retrig_at = -1;
        if ($urandom_range(0, 3) == 0 && span > trig_hi + 2)
          retrig_at = $urandom_range(trig_hi + 1, span - 1);
        for (int t = 0; t < span; t++) begin
          trig = int'((t < trig_hi) || (t == retrig_at));
          queue_tick(trig, ((t + phase) / hp) % 2, len, $urandom_range(0, 65535),
                     pick_thr(), int'($urandom_range(0, 299) == 0));
        end
      end
      queued += span;
    end
  endtask

  // Wait until every tick went out and every result came back, plus a margin
  task automatic wait_drained();
    while (ticks_to_send.size() != 0 || s_axis_tvalid || burst_results_due.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic retrig, input logic [cbg_pkg::MARK_W-1:0] ticks);
    @(posedge clk);
    wr_en    <= 1'b1;
    wr_index <= cbg_pkg::REG_RETRIGGER;
    wr_data  <= {{(cbg_pkg::MARK_W-1){1'b0}}, retrig};
    @(posedge clk);
    wr_index <= cbg_pkg::REG_MARKER_TICKS;
    wr_data  <= ticks;
    @(posedge clk);
    wr_en    <= 1'b0;
    retrig_en = retrig;
    mark_len  = ticks;
    settings_used++;
  endtask

  // Driver: predicts each accepted tick, then offers the next one
  always @(posedge clk) begin
    bit         offer;
    tick_item_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        burst_results_due.push_back(next_burst_result(s_axis_tdata));
        ticks_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        offer = ticks_to_send.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct;
        if (offer && ticks_to_send[0].hold && burst_results_due.size() != 0) offer = 0;
        if (offer) begin
          nxt = ticks_to_send.pop_front();
          s_axis_tdata  <= nxt.data;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transfer with the oldest owed result
  always @(posedge clk) begin
    cbg_pkg::core_out_t got;
    cbg_pkg::core_out_t want;
    bit                 bad;
    bit                 owed;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.pulse      = m_axis_tdata[0];
        got.duration   = m_axis_tdata[1];
        got.start_fire = m_axis_tdata[2];
        got.end_fire   = m_axis_tdata[3];
        got.step       = m_axis_tdata[9:4];
        owed = (burst_results_due.size() != 0);
        bad  = 1'b1;
        want = '0;
        if (owed) begin
          want = burst_results_due.pop_front();
          bad  = (got.pulse != want.pulse) || (got.duration != want.duration) ||
                 (got.start_fire != want.start_fire) || (got.end_fire != want.end_fire) ||
                 (got.step != want.step);
        end
        if (bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch at %0t: exp pulse=%b dur=%b start=%b end=%b step=%0d%s",
                     $realtime, want.pulse, want.duration, want.start_fire, want.end_fire,
                     want.step, owed ? "" : " (none owed)");
          if (mismatches <= 10)
            $display("            got pulse=%b dur=%b start=%b end=%b step=%0d",
                     got.pulse, got.duration, got.start_fire, got.end_fire, got.step);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Stimulus sequence
  initial begin
    retrig_en  = 1'b0;
    mark_len   = cbg_pkg::MARKER_TICKS_RST;
    trig_q     = 1'b0;
    clk_q      = 1'b0;
    pulse_cnt  = -1;
    active     = 1'b0;
    active_q   = 1'b0;
    start_pend = 1'b0;
    fire_ok    = 1'b1;
    exp_on     = 1'b0;
    exp_cnt    = '0;
    start_tmr  = '0;
    end_tmr    = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: arm with clock high, gate extremes, short burst, clamps
    snd_idle_pct = 35;
    rcv_idle_pct = 50;
    write_regs(1'b0, cbg_pkg::MARK_W'(3));
    queue_tick(1, 1, 2, 0, 1, 0);
    queue_tick(1, 0, 2, 0, 1, 0);
    queue_tick(0, 1, 2, 65535, 65535, 0);
    queue_tick(0, 0, 2, 0, 0, 0);
    queue_tick(0, 0, 2, 0, 0, 0);
    queue_tick(0, 0, 2, 0, 0, 1);
    // length zero acts as one pulse
    queue_tick(1, 1, 0, 65535, 65536, 0);
    queue_tick(0, 0, 0, 0, 0, 0);
    queue_tick(0, 1, 0, 0, 0, 0);
    queue_tick(0, 0, 0, 0, 0, 0);
    // threshold above 65536 always passes
    queue_tick(1, 0, 1, 65535, 131071, 0);
    queue_tick(0, 1, 1, 65535, 131071, 0);
    queue_tick(0, 0, 1, 65535, 131071, 0);
    // oversized length clamps; trigger again while running is ignored
    queue_tick(1, 1, 63, 65535, 131071, 0);
    queue_tick(0, 0, 63, 0, 0, 0);
    queue_tick(1, 1, 63, 0, 0, 0);
    queue_tick(0, 0, 33, 0, 65536, 0);
    queue_tick(0, 1, 32, 0, 1, 0);
    queue_tick(0, 0, 32, 0, 0, 0);
    queue_tick(1, 1, 63, 65535, 131071, 0);
    queue_tick(0, 0, 0, 0, 0, 0);
    queue_random_ticks(360);
    wait_drained();

    write_regs(1'b1, cbg_pkg::MARK_W'(1));
    queue_random_ticks(380);
    wait_drained();

    // Swap who stalls
    snd_idle_pct = 50;
    rcv_idle_pct = 35;
    write_regs(1'b1, cbg_pkg::MARK_W'(0));
    queue_random_ticks(300);
    wait_drained();

    write_regs(1'b0, cbg_pkg::MARK_W'(65535));
    queue_random_ticks(300);
    wait_drained();

    // Full rate both sides
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    write_regs(1'b1, cbg_pkg::MARK_W'($urandom_range(2, 40)));
    queue_random_ticks(300);
    wait_drained();

    write_regs(1'b0, cbg_pkg::MARKER_TICKS_RST);
    queue_random_ticks(200);
    wait_drained();

    mismatches += burst_results_due.size();
    $display("run covered %0d ticks over %0d register settings", ticks_sent, settings_used);
    $display("model saw %0d bursts and %0d gated pulses; %0d mismatches",
             bursts_armed, pulses_fired, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: clocked_burst_generator_unit.f
src/cbg_pkg.sv
src/cbg_marker.sv
src/cbg_core.sv
src/clocked_burst_generator_unit.sv
verif/clocked_burst_generator_unit_tb.sv
